### rtl/lnorm_pkg.sv
// Shared types and constants for the layer normalization block.
`timescale 1ns / 1ps
package lnorm_pkg;
	localparam int CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] REG_ROW_LENGTH = 1'd0;
	localparam logic [CfgIdxW-1:0] REG_EPSILON = 1'd1;
	localparam int CfgDataW = 16;
	localparam int RowLenW = 7;
	localparam int EpsW = 16;
	localparam int InvW = 25;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_DIV_MEAN,
		ST_VAR_RD,
		ST_VAR_ACC,
		ST_DIV_VAR,
		ST_DIV_INV,
		ST_RSQ,
		ST_RSQ_CHK,
		ST_OUT_RD,
		ST_OUT_MUL1,
		ST_OUT_MUL2,
		ST_OUT_SAT,
		ST_OUT_HOLD,
		ST_ERR
	} state_t;
endpackage

### rtl/lnorm_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
`timescale 1ns / 1ps
module lnorm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/lnorm_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend, unsigned divisor.
`timescale 1ns / 1ps
module lnorm_div #(
	parameter int NW = 48,
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          neg,
	input  logic [NW-1:0] magnitude,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);
	localparam int CntW = $clog2(NW + 1);
	logic [NW-1:0] num_q, quo_q;
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic busy_q, neg_q;
	logic [DW:0] trial;

	assign trial = {rem_q[DW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CntW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= magnitude;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	// truncation toward zero: negate the magnitude quotient
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;
endmodule

### rtl/layer_normalization.sv
// Layer normalization over rows of signed Q8.8 elements. Each request carries an element
// with its gain and offset; the row is buffered in one RAM until tlast. The mean comes from
// the running sum through a shift-subtract divider (one bit a cycle, 57 steps), the variance
// from a second pass over the RAM (a read and an accumulate state an element) and the same
// divider, then floor(2^48 / (variance + epsilon)) from a second serial divider (49 steps)
// and the inverse deviation from a bit-by-bit square root search on that quotient (25 steps,
// each a square and a check state). The results come from a third pass through the read,
// two multiply, saturate and hold states, which waits in the hold state for m_tready.
// Loading accepts one element per cycle while s_tvalid is high. A row of the wrong length,
// or longer than MAX_ROW, gives one result with length_error set.
// No element is accepted while a row is being processed.
`timescale 1ns / 1ps
module layer_normalization #(
	parameter int MAX_ROW = 64,
	parameter int DATA_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [lnorm_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [lnorm_pkg::CfgDataW-1:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	// sample, scale, shift (DATA_WIDTH each, lowest first), zero padded to bytes
	input  logic [((3*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic s_tlast,
	output logic m_tvalid,
	input  logic m_tready,
	// normalized, centered, row_mean, inv_deviation, length_error (lowest first), padded
	output logic [((3*DATA_WIDTH+27+7)/8)*8-1:0] m_tdata,
	output logic m_tlast
);
	import lnorm_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int AW = $clog2(MAX_ROW);
	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int SW = DW + CW;
	localparam int QW = 2 * DW + 2 + CW;
	localparam int OW = ((3*DW+27+7)/8)*8;
	localparam int DIVW = QW + 16;
	localparam int InvNW = 49;
	localparam int QSW = 2*DW+InvW+1;
	localparam logic [DIVW-1:0] DivOnes = '1;
	localparam logic [InvNW-1:0] InvNum = InvNW'(1) << 48;
	localparam logic signed [QSW-1:0] SatHi = QSW'((64'sd1 <<< (DW-1)) - 64'sd1);
	localparam logic signed [QSW-1:0] SatLo = ~SatHi;

	state_t state_q, state_d;
	logic [RowLenW-1:0] row_length_q;
	logic [EpsW-1:0] epsilon_q;
	logic [CW-1:0] count_q;
	logic signed [SW-1:0] sum_q;
	logic ovf_q;
	logic [AW-1:0] idx_q;
	logic signed [DW-1:0] mean_q;
	logic [QW-1:0] sumsq_q;
	logic [InvW-1:0] r_q;
	logic [4:0] bit_q;
	logic [2*InvW-1:0] r2_q;
	logic signed [DW:0] c_s1;
	logic signed [DW+InvW+1:0] cr_s1;
	logic signed [2*DW+InvW:0] q_s2;
	logic signed [DW-1:0] g_s1, b_s1, b_s2;
	logic lastel_q;

	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic [3*DW-1:0] ram_rdata;

	lnorm_ram #(.WIDTH(3*DW), .DEPTH(MAX_ROW)) u_ram (
		.clk(clk), .we(ram_we), .waddr(count_q[AW-1:0]), .wdata(s_tdata[3*DW-1:0]),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// shared divider, used for the mean and the variance
	logic div_start, div_neg, div_done;
	logic [DIVW-1:0] div_mag, div_quo;
	logic [CW-1:0] div_den;
	// the mean starts on the tlast request, before the count takes the last element in
	assign div_den = (state_q == ST_LOAD) ? CW'(count_q + 1'b1) : count_q;
	lnorm_div #(.NW(DIVW), .DW(CW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .neg(div_neg), .magnitude(div_mag),
		.divisor(div_den), .done(div_done), .quotient(div_quo)
	);

	// variance plus epsilon, saturating
	logic [DIVW-1:0] v_next;
	assign v_next = (div_quo > DivOnes - DIVW'(epsilon_q)) ? DivOnes :
	                div_quo + DIVW'(epsilon_q);

	// 2^48 / (variance + epsilon); a zero divisor gives all ones, so r reaches its ceiling
	logic inv_start, inv_done;
	logic [InvNW-1:0] inv_quo;
	assign inv_start = (state_q == ST_DIV_VAR) && div_done;
	lnorm_div #(.NW(InvNW), .DW(DIVW)) u_inv (
		.clk(clk), .arst_n(arst_n), .start(inv_start), .neg(1'b0), .magnitude(InvNum),
		.divisor(v_next), .done(inv_done), .quotient(inv_quo)
	);

	logic accept, last_acc;
	assign accept = s_tvalid && s_tready;
	assign last_acc = accept && s_tlast;
	assign ram_we = accept && (count_q < CW'(MAX_ROW));
	assign ram_raddr = idx_q;

	logic signed [DW:0] d_rd;
	logic [DW:0] ad_rd;
	assign d_rd = $signed({ram_rdata[DW-1], ram_rdata[DW-1:0]}) - mean_q;
	assign ad_rd = d_rd[DW] ? (~d_rd + 1'b1) : d_rd;

	logic [InvW-1:0] cand;
	logic cand_ok;
	assign cand = r_q | (InvW'(1) << bit_q);
	// r never exceeds 2^24
	assign cand_ok = !(cand[InvW-1] && (cand[InvW-2:0] != '0));
	// r*r*v <= 2^48 holds exactly when r*r <= floor(2^48 / v)

	logic [OW-1:0] out_q;
	logic out_last_q;
	assign m_tdata = out_q;
	assign m_tlast = out_last_q;
	assign s_tready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		m_tvalid = 1'b0;
		div_start = 1'b0;
		div_neg = 1'b0;
		div_mag = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (last_acc) begin
					if (ovf_q || count_q >= CW'(MAX_ROW) ||
					    RowLenW'(count_q + 1'b1) != row_length_q ||
					    {1'b0, count_q} + 1'b1 != (CW+1)'(row_length_q))
						state_d = ST_ERR;
					else
						state_d = ST_DIV_MEAN;
				end
			end
			ST_DIV_MEAN: if (div_done) state_d = ST_VAR_RD;
			ST_VAR_RD: state_d = ST_VAR_ACC;
			ST_VAR_ACC: state_d = lastel_q ? ST_DIV_VAR : ST_VAR_RD;
			ST_DIV_VAR: if (div_done) state_d = ST_DIV_INV;
			ST_DIV_INV: if (inv_done) state_d = ST_RSQ;
			ST_RSQ: state_d = ST_RSQ_CHK;
			ST_RSQ_CHK: state_d = (bit_q == 5'd0) ? ST_OUT_RD : ST_RSQ;
			ST_OUT_RD: state_d = ST_OUT_MUL1;
			ST_OUT_MUL1: state_d = ST_OUT_MUL2;
			ST_OUT_MUL2: state_d = ST_OUT_SAT;
			ST_OUT_SAT: state_d = ST_OUT_HOLD;
			ST_OUT_HOLD: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = out_last_q ? ST_LOAD : ST_OUT_RD;
			end
			ST_ERR: begin
				m_tvalid = 1'b1;
				if (m_tready) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
		if (state_q == ST_LOAD && state_d == ST_DIV_MEAN) begin
			div_start = 1'b1;
			div_neg = sum_q[SW-1] ^ s_tdata[DW-1] ?
				(sum_q + $signed(s_tdata[DW-1:0])) < 0 : sum_q[SW-1];
			div_mag = (sum_q + $signed(s_tdata[DW-1:0])) < 0 ?
				DIVW'(-(sum_q + $signed(s_tdata[DW-1:0]))) :
				DIVW'(sum_q + $signed(s_tdata[DW-1:0]));
		end
		if (state_q == ST_VAR_ACC && lastel_q) begin
			div_start = 1'b1;
			div_mag = DIVW'(sumsq_q + ad_rd * ad_rd);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			row_length_q <= RowLenW'(64);
			epsilon_q <= EpsW'(1);
			count_q <= '0;
			sum_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ROW_LENGTH: row_length_q <= cfg_data[RowLenW-1:0];
					REG_EPSILON: epsilon_q <= cfg_data[EpsW-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (count_q < CW'(MAX_ROW)) begin
					count_q <= count_q + 1'b1;
					sum_q <= sum_q + $signed(s_tdata[DW-1:0]);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			// the count stays for the divider; cleared once the row is done
			if (last_acc) ovf_q <= 1'b0;
			if (last_acc && state_d == ST_ERR) begin
				count_q <= '0;
				sum_q <= '0;
			end
			if (state_q == ST_OUT_HOLD && m_tready && out_last_q) begin
				count_q <= '0;
				sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_LOAD: begin
				idx_q <= '0;
				sumsq_q <= '0;
				lastel_q <= (count_q == '0);
			end
			ST_DIV_MEAN: if (div_done) mean_q <= div_quo[DW-1:0];
			ST_VAR_RD: idx_q <= idx_q + 1'b1;
			ST_VAR_ACC: begin
				sumsq_q <= sumsq_q + QW'(ad_rd * ad_rd);
				lastel_q <= ({1'b0, idx_q} == CW'(count_q - 1'b1)) ||
				            (idx_q == '0 && count_q == CW'(MAX_ROW));
				r_q <= '0;
				bit_q <= 5'd24;
			end
			ST_DIV_VAR: if (div_done) idx_q <= '0;
			ST_RSQ: r2_q <= cand * cand;
			ST_RSQ_CHK: begin
				if (cand_ok && r2_q <= {1'b0, inv_quo}) r_q <= cand;
				bit_q <= bit_q - 1'b1;
			end
			ST_OUT_RD: lastel_q <= ({1'b0, idx_q} == CW'(count_q - 1'b1));
			ST_OUT_MUL1: begin
				c_s1 <= d_rd;
				cr_s1 <= (DW+InvW+2)'(d_rd * $signed({1'b0, r_q}));
				g_s1 <= ram_rdata[2*DW-1:DW];
				b_s1 <= ram_rdata[3*DW-1:2*DW];
			end
			ST_OUT_MUL2: begin
				q_s2 <= (2*DW+InvW+1)'((cr_s1 >>> 16) * g_s1);
				b_s2 <= b_s1;
			end
			ST_OUT_HOLD: if (m_tready) idx_q <= idx_q + 1'b1;
			default: ;
		endcase
		if (state_q == ST_OUT_SAT) begin
			out_q <= OW'({1'b0, r_q, mean_q, d_unused(c_s1), sat_next(q_s2, b_s2)});
			out_last_q <= lastel_q;
		end
		if (state_q == ST_LOAD && state_d == ST_ERR) begin
			out_q <= OW'({1'b1, {(3*DW+26){1'b0}}});
			out_last_q <= 1'b1;
		end
	end

	function automatic logic [DW:0] d_unused(input logic signed [DW:0] c);
		return c;
	endfunction

	// floor shift by 8, add the offset, saturate; kept at full width so nothing wraps
	function automatic logic [DW-1:0] sat_next(input logic signed [QSW-1:0] q,
	                                             input logic signed [DW-1:0] b);
		logic signed [QSW-1:0] t;
		t = (q >>> 8) + QSW'(b);
		if (t > SatHi) return {1'b0, {(DW-1){1'b1}}};
		if (t < SatLo) return {1'b1, {(DW-1){1'b0}}};
		return t[DW-1:0];
	endfunction
endmodule
